>>> hw/rtl/arp_cache_table_defines.svh
// assertion macros for the arp cache table checker
// expects clk_i and rst_ni to be visible where a macro is used
`ifndef ARP_CACHE_TABLE_DEFINES_SVH
`define ARP_CACHE_TABLE_DEFINES_SVH

// plain property, sampled on the rising clock and off during reset
`define ARPC_ASSERT(label, prop, msg) \
  label: assert property (@(posedge clk_i) disable iff (!rst_ni) (prop)) else $error(msg);

// same-cycle implication
`define ARPC_ASSERT_IMP(label, ante, cons, msg) \
  `ARPC_ASSERT(label, (ante) |-> (cons), msg)

// next-cycle implication
`define ARPC_ASSERT_NXT(label, ante, cons, msg) \
  `ARPC_ASSERT(label, (ante) |=> (cons), msg)

`endif

>>> hw/rtl/arpc_pkg.sv
// shared types and constants of the arp cache table
// request/response payloads, controller/datapath command and status, kind codes
package arpc_pkg;

  localparam int unsigned EntriesDefault = 16;

  localparam int unsigned IpW    = 32;
  localparam int unsigned MacW   = 48;
  localparam int unsigned StampW = 32;
  localparam int unsigned SlotW  = 4;
  localparam int unsigned KindW  = 3;
  localparam int unsigned StaleW = 16;
  localparam int unsigned CountW = 5;

  localparam logic [StaleW-1:0] StaleTimeReset = 16'd15;
  localparam logic [CountW-1:0] StaleCountMax  = 5'd31;

  localparam logic [KindW-1:0] KIND_INSERT = 3'd0;
  localparam logic [KindW-1:0] KIND_LOOKUP = 3'd1;
  localparam logic [KindW-1:0] KIND_READ   = 3'd2;
  localparam logic [KindW-1:0] KIND_TICK   = 3'd3;
  localparam logic [KindW-1:0] KIND_SWEEP  = 3'd4;

  typedef struct packed {
    logic [KindW-1:0] kind;
    logic [IpW-1:0]   ip_addr;
    logic [MacW-1:0]  mac_addr;
    logic [SlotW-1:0] entry_index;
  } arpc_req_t;

  typedef struct packed {
    logic              hit;
    logic [SlotW-1:0]  found_index;
    logic [MacW-1:0]   mac_out;
    logic              dropped;
    logic [CountW-1:0] stale_count;
  } arpc_rsp_t;

  typedef struct packed {
    logic [IpW-1:0]    ip;
    logic [MacW-1:0]   mac;
    logic [StampW-1:0] stamp;
  } arpc_entry_t;

  typedef struct packed {
    logic load;
    logic tick;
    logic ins_step;
    logic walk_step;
    logic rd_issue;
    logic rd_capture;
  } arpc_cmd_t;

  typedef struct packed {
    logic ins_done;
    logic walk_done;
  } arpc_sts_t;

endpackage

>>> hw/rtl/arpc_ctrl.sv
// controller state machine of the arp cache table
// depends on arpc_pkg; drives arpc_datapath through arpc_cmd_t
module arpc_ctrl (
  input  logic                            clk_i,
  input  logic                            rst_ni,
  input  logic                            start,
  output logic                            busy,
  input  logic [arpc_pkg::KindW-1:0]      kind_i,
  input  arpc_pkg::arpc_sts_t             sts_i,
  output arpc_pkg::arpc_cmd_t             cmd_o,
  output logic                            done_o
);
  import arpc_pkg::*;

  localparam logic [2:0] S_IDLE    = 3'd0;
  localparam logic [2:0] S_INS     = 3'd1;
  localparam logic [2:0] S_WALK    = 3'd2;
  localparam logic [2:0] S_RD_ISS  = 3'd3;
  localparam logic [2:0] S_RD_DATA = 3'd4;
  localparam logic [2:0] S_DONE    = 3'd5;

  logic [2:0] state_q, state_d;

  always_comb begin
    state_d = state_q;
    cmd_o   = '0;
    unique case (state_q)
      S_IDLE: begin
        if (start) begin
          cmd_o.load = 1'b1;
          unique case (kind_i) inside
            KIND_INSERT: state_d = S_INS;
            KIND_LOOKUP, KIND_SWEEP: state_d = S_WALK;
            KIND_READ: state_d = S_RD_ISS;
            KIND_TICK: begin
              cmd_o.tick = 1'b1;
              state_d    = S_DONE;
            end
            default: state_d = S_DONE;
          endcase
        end
      end
      S_INS: begin
        cmd_o.ins_step = 1'b1;
        if (sts_i.ins_done) state_d = S_DONE;
      end
      S_WALK: begin
        cmd_o.walk_step = 1'b1;
        if (sts_i.walk_done) state_d = S_DONE;
      end
      S_RD_ISS: begin
        cmd_o.rd_issue = 1'b1;
        state_d        = S_RD_DATA;
      end
      S_RD_DATA: begin
        cmd_o.rd_capture = 1'b1;
        state_d          = S_DONE;
      end
      S_DONE: state_d = S_IDLE;
      default: state_d = S_IDLE;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= S_IDLE;
    end else begin
      state_q <= state_d;
    end
  end

  assign busy   = (state_q != S_IDLE);
  assign done_o = (state_q == S_DONE);

endmodule

>>> hw/rtl/arpc_datapath.sv
// datapath of the arp cache table: entry memory, valid bits, clock and walk pipeline
// depends on arpc_pkg; commanded by arpc_ctrl
module arpc_datapath #(
  parameter int unsigned Entries = arpc_pkg::EntriesDefault
) (
  input  logic                              clk_i,
  input  logic                              rst_ni,
  input  arpc_pkg::arpc_req_t               req_i,
  input  logic                              cfg_we_i,
  input  logic [arpc_pkg::StaleW-1:0]       cfg_wdata_i,
  input  arpc_pkg::arpc_cmd_t               cmd_i,
  output arpc_pkg::arpc_sts_t               sts_o,
  output arpc_pkg::arpc_rsp_t               rsp_o
);
  import arpc_pkg::*;

  localparam int unsigned IdxW = (Entries > 1) ? $clog2(Entries) : 1;
  localparam int unsigned CntW = $clog2(Entries + 1);
  localparam logic [IdxW-1:0] LastIdx = IdxW'(Entries - 1);
  localparam logic [CntW-1:0] EntCnt  = CntW'(Entries);

  // entry memory, one write and one registered read port
  arpc_entry_t mem_q [Entries];
  arpc_entry_t rd_data_q;
  logic        wr_en, rd_en;
  logic [IdxW-1:0] wr_addr, rd_addr;
  arpc_entry_t wr_data;

  logic [Entries-1:0] valid_q, valid_d;
  logic [StampW-1:0]  seconds_q, seconds_d;
  logic [StaleW-1:0]  stale_time_q;
  logic [CntW-1:0]    iss_q, iss_d;
  logic [IdxW-1:0]    cmp_q, cmp_d;
  logic               cmp_vld_q, cmp_vld_d;
  arpc_req_t          req_q, req_d;
  arpc_rsp_t          rsp_q, rsp_d;

  logic [IdxW-1:0]   scan_idx;
  logic              scan_free;
  logic              is_lookup, is_sweep;
  logic              ip_match, too_old, in_range;
  logic [StampW-1:0] age;

  assign scan_idx  = iss_q[IdxW-1:0];
  assign scan_free = !valid_q[scan_idx];
  assign is_lookup = (req_q.kind == KIND_LOOKUP);
  assign is_sweep  = (req_q.kind == KIND_SWEEP);
  assign ip_match  = valid_q[cmp_q] && (rd_data_q.ip == req_q.ip_addr);
  assign age       = seconds_q - rd_data_q.stamp;
  assign too_old   = valid_q[cmp_q] && (age > {{(StampW-StaleW){1'b0}}, stale_time_q});
  assign in_range  = (32'(req_q.entry_index) < 32'(Entries));

  assign sts_o.ins_done  = scan_free || (scan_idx == LastIdx);
  assign sts_o.walk_done = cmp_vld_q && ((is_lookup && ip_match) || (cmp_q == LastIdx));

  always_comb begin
    valid_d   = valid_q;
    seconds_d = seconds_q;
    iss_d     = iss_q;
    cmp_d     = cmp_q;
    cmp_vld_d = cmp_vld_q;
    req_d     = req_q;
    rsp_d     = rsp_q;
    wr_en     = 1'b0;
    wr_addr   = scan_idx;
    wr_data   = '{ip: req_q.ip_addr, mac: req_q.mac_addr, stamp: seconds_q};
    rd_en     = 1'b0;
    rd_addr   = scan_idx;

    if (cmd_i.load) begin
      req_d     = req_i;
      rsp_d     = '0;
      iss_d     = '0;
      cmp_vld_d = 1'b0;
    end

    if (cmd_i.tick) seconds_d = seconds_q + 32'd1;

    if (cmd_i.ins_step) begin
      if (scan_free) begin
        wr_en              = 1'b1;
        valid_d[scan_idx]  = 1'b1;
        rsp_d.hit          = 1'b1;
        rsp_d.found_index  = SlotW'(scan_idx);
        rsp_d.mac_out      = req_q.mac_addr;
      end else if (scan_idx == LastIdx) begin
        rsp_d.dropped = 1'b1;
      end else begin
        iss_d = iss_q + CntW'(1);
      end
    end

    if (cmd_i.walk_step) begin
      // issue stage: one slot address per cycle
      if (iss_q < EntCnt) begin
        rd_en     = 1'b1;
        cmp_d     = scan_idx;
        cmp_vld_d = 1'b1;
        iss_d     = iss_q + CntW'(1);
      end else begin
        cmp_vld_d = 1'b0;
      end
      // compare stage on the slot read last cycle
      if (cmp_vld_q) begin
        if (is_lookup && ip_match) begin
          rsp_d.hit         = 1'b1;
          rsp_d.found_index = SlotW'(cmp_q);
          rsp_d.mac_out     = rd_data_q.mac;
        end
        if (is_sweep && too_old) begin
          valid_d[cmp_q] = 1'b0;
          if (rsp_q.stale_count != StaleCountMax) begin
            rsp_d.stale_count = rsp_q.stale_count + CountW'(1);
          end
        end
      end
    end

    if (cmd_i.rd_issue) begin
      rd_en   = 1'b1;
      rd_addr = IdxW'(req_q.entry_index);
    end

    if (cmd_i.rd_capture) begin
      rsp_d.mac_out = in_range ? rd_data_q.mac : '0;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      valid_q      <= '0;
      seconds_q    <= '0;
      stale_time_q <= StaleTimeReset;
      iss_q        <= '0;
      cmp_vld_q    <= 1'b0;
    end else begin
      valid_q   <= valid_d;
      seconds_q <= seconds_d;
      iss_q     <= iss_d;
      cmp_vld_q <= cmp_vld_d;
      if (cfg_we_i) stale_time_q <= cfg_wdata_i;
    end
  end

  always_ff @(posedge clk_i) begin
    req_q <= req_d;
    rsp_q <= rsp_d;
    cmp_q <= cmp_d;
  end

  always_ff @(posedge clk_i) begin
    if (wr_en) mem_q[wr_addr] <= wr_data;
    if (rd_en) rd_data_q <= mem_q[rd_addr];
  end

  assign rsp_o = rsp_q;

endmodule

>>> hw/rtl/arp_cache_table.sv
// top level of the arp cache table
// depends on arpc_pkg, arpc_ctrl and arpc_datapath
//
// A request is taken at a rising edge with start high and busy low; busy stays
// high until the result has been shown. The result is shown on rsp_o while done_o
// is high for exactly one cycle and is taken at the edge ending that cycle; the
// receiver has no way to hold it off, and every request gives exactly one result.
// The stale time register is written whenever cfg_we_i is high; the user must
// write it only while idle, which the block itself does not enforce. busy falls
// in the cycle after the result, when the next request can be taken. Insert
// scans the valid bits one slot per cycle and stops at the lowest free slot.
// Lookup and sweep walk one slot per cycle through the single read port of the
// entry memory; lookup stops at the first hit, and sweep visits every slot.
// Reset clears every valid bit and the seconds counter, and sets the stale time
// to 15; the stored addresses and stamps keep whatever they hold.
module arp_cache_table #(
  parameter int unsigned Entries = arpc_pkg::EntriesDefault
) (
  input  logic                            clk_i,
  input  logic                            rst_ni,
  input  logic                            start,
  output logic                            busy,
  input  arpc_pkg::arpc_req_t             req_i,
  output logic                            done_o,
  output arpc_pkg::arpc_rsp_t             rsp_o,
  input  logic                            cfg_we_i,
  input  logic [arpc_pkg::StaleW-1:0]     cfg_wdata_i
);
  import arpc_pkg::*;

  arpc_cmd_t cmd;
  arpc_sts_t sts;

  arpc_ctrl u_ctrl (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .start  (start),
    .busy   (busy),
    .kind_i (req_i.kind),
    .sts_i  (sts),
    .cmd_o  (cmd),
    .done_o (done_o)
  );

  arpc_datapath #(
    .Entries (Entries)
  ) u_dp (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .req_i       (req_i),
    .cfg_we_i    (cfg_we_i),
    .cfg_wdata_i (cfg_wdata_i),
    .cmd_i       (cmd),
    .sts_o       (sts),
    .rsp_o       (rsp_o)
  );

endmodule

>>> hw/rtl/arpc_checker.sv
// port-level checker of the arp cache table, bound to the top level
// depends on arpc_pkg and arp_cache_table_defines.svh
`include "arp_cache_table_defines.svh"

module arpc_checker (
  input logic                clk_i,
  input logic                rst_ni,
  input logic                start,
  input logic                busy,
  input logic                done_o,
  input arpc_pkg::arpc_rsp_t rsp_o
);
  import arpc_pkg::*;

  `ARPC_ASSERT_NXT(a_accept_busy, start && !busy, busy, "accepted request did not raise busy")
  `ARPC_ASSERT_NXT(a_done_single, done_o, !done_o && !busy, "result shown longer than one cycle")
  `ARPC_ASSERT_IMP(a_drop_clean, done_o && rsp_o.dropped, !rsp_o.hit && rsp_o.found_index == '0 && rsp_o.mac_out == '0 && rsp_o.stale_count == '0, "dropped insert with nonzero fields")
  `ARPC_ASSERT_IMP(a_sweep_only, done_o && rsp_o.stale_count != '0, !rsp_o.hit && !rsp_o.dropped && rsp_o.mac_out == '0, "sweep result mixed with other fields")

endmodule

bind arp_cache_table arpc_checker u_arpc_checker (
  .clk_i  (clk_i),
  .rst_ni (rst_ni),
  .start  (start),
  .busy   (busy),
  .done_o (done_o),
  .rsp_o  (rsp_o)
);
